FILE: sv/kvt_pkg.sv
// Shared types and constants for the key/value table core.
// Used by the channel interfaces, the table cell and the top level; no dependencies.
package kvt_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;
   localparam int ACT_W    = 2;
   localparam int STAT_W   = 2;
   localparam int CNT_OUT_W = 5;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int COUNT_W  = (CNT_BITS > CNT_OUT_W) ? CNT_BITS : CNT_OUT_W;

   localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd3;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic                    commit;
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } cmd_type;

   // Word handed from one cell to the next along the row.
   typedef struct packed {
      logic             free_seen;
      logic             hit_seen;
      logic [VAL_W-1:0] hit_value;
   } chain_type;

endpackage

FILE: sv/kvt_req_if.sv
// Request channel: valid/ready handshake carrying action, key and value.
// Depends on kvt_pkg for field widths.
interface kvt_req_if import kvt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        action;
   logic signed [KEY_W-1:0] key;
   logic [VAL_W-1:0]        value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

FILE: sv/kvt_rsp_if.sv
// Response channel: valid/ready handshake carrying status, found, value and count.
// Depends on kvt_pkg for field widths.
interface kvt_rsp_if import kvt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic                 found;
   logic [VAL_W-1:0]     result_value;
   logic [CNT_OUT_W-1:0] count;

   modport source (output valid, status, found, result_value, count, input ready);
   modport sink   (input valid, status, found, result_value, count, output ready);
endinterface

FILE: sv/key_value_table_core.sv
// Key/value table core: a row of ENTRIES cells searched in parallel.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and kvt_cell.
//
// Usage:
//   req_ch carries one operation per word: action (put, get, remove), key and
//   value. rsp_ch returns one word per operation: status, found, result_value
//   and the pair count after the operation (low five bits).
//   A request is registered on acceptance; in the lookup step that follows, every cell
//   compares the key, the row hands the free-slot and hit marks from cell to cell, the
//   cells update and the response register loads. A request is taken only in the
//   idle step, so each operation finishes its compare and write-back pass through
//   the cell row before the next is accepted.
//   A new request is accepted while an earlier response still waits. If the
//   receiver stalls, the finished operation holds in the lookup step (table
//   not yet updated) until the response register frees, and no further
//   request is taken.
//   Reset clears the valid marks, the count and both channel handshakes;
//   keys and values are not cleared and are read only from valid slots.
module key_value_table_core import kvt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   kvt_req_if.sink   req_ch,
   kvt_rsp_if.source rsp_ch
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOOK = 1'b1;

   logic                    state_ff, state_in;
   logic [ACT_W-1:0]        action_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0]        value_ff;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    rsp_status_ff, status_in;
   logic                 rsp_found_ff, found_in;
   logic [VAL_W-1:0]     rsp_value_ff, value_in;

   logic          commit;
   logic          accept;
   cmd_type       cmd;
   chain_type     chain [ENTRIES+1];
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] valid_vec;
   logic          any_hit;
   logic          any_free;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign commit = (state_ff == S_LOOK) && (!rsp_valid_ff || rsp_ch.ready);

   assign chain[0] = '0;
   assign any_hit  = chain[ENTRIES].hit_seen;
   assign any_free = chain[ENTRIES].free_seen;

   always_comb begin
      cmd.commit  = commit;
      cmd.action  = action_ff;
      cmd.key     = key_ff;
      cmd.value   = value_ff;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kvt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .any_hit   (any_hit),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .match     (match_vec[i]),
         .valid     (valid_vec[i])
      );
   end

   always_comb begin
      status_in = STAT_MISSING;
      found_in  = 1'b0;
      value_in  = '0;
      count_in  = count_ff;
      unique case (action_ff)
         ACT_PUT: begin
            if (any_hit) begin
               status_in = STAT_UPDATED;
               found_in  = 1'b1;
            end else if (any_free) begin
               status_in = STAT_INSERTED;
               count_in  = count_ff + COUNT_W'(1);
            end else begin
               status_in = STAT_FULL;
            end
         end
         ACT_GET: begin
            if (any_hit) begin
               status_in = STAT_UPDATED;
               found_in  = 1'b1;
               value_in  = chain[ENTRIES].hit_value;
            end
         end
         ACT_REMOVE: begin
            if (any_hit) begin
               status_in = STAT_UPDATED;
               found_in  = 1'b1;
               value_in  = chain[ENTRIES].hit_value;
               count_in  = count_ff - COUNT_W'(1);
            end
         end
         default: begin
            status_in = STAT_MISSING;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_LOOK;
         S_LOOK:  if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request word for the lookup step.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_ch.action;
         key_ff    <= req_ch.key;
         value_ff  <= req_ch.value;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_value_ff  <= value_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.count        = count_ff[CNT_OUT_W-1:0];

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOOK |-> $onehot0(match_vec))
      else $error("more than one slot matches the key");

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("pair count disagrees with valid marks");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished operation did not load a response");

   a_no_accept_in_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOOK && !commit |=> state_ff == S_LOOK && $stable(key_ff))
      else $error("stalled operation lost its request word");

endmodule

FILE: sv/kvt_cell.sv
// One slot of the table: key, value and valid mark, with its compare and update logic.
// Depends on kvt_pkg; chained with its neighbors by the top level.
module kvt_cell import kvt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      any_hit,
   input  chain_type chain_in,
   output chain_type chain_out,
   output logic      match,
   output logic      valid
);

   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             valid_ff;
   logic             claim;

   assign match = valid_ff && (key_ff == cmd.key);
   assign valid = valid_ff;

   // First free slot in the row takes an insert.
   assign claim = !valid_ff && !chain_in.free_seen;

   always_comb begin
      chain_out.free_seen = chain_in.free_seen | !valid_ff;
      chain_out.hit_seen  = chain_in.hit_seen | match;
      chain_out.hit_value = chain_in.hit_value | (match ? value_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         if (cmd.action == ACT_PUT && !any_hit && claim) begin
            valid_ff <= 1'b1;
         end else if (cmd.action == ACT_REMOVE && match) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && cmd.action == ACT_PUT) begin
         if (match) begin
            value_ff <= cmd.value;
         end else if (!any_hit && claim) begin
            key_ff   <= cmd.key;
            value_ff <= cmd.value;
         end
      end
   end

endmodule

FILE: tb/tb_key_value_table_core.sv
// Testbench for key_value_table_core: drives put/get/remove words and checks each response
// against a table model kept here. Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and the core.
module tb_key_value_table_core;
   import kvt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;   // unused action code, ignored by the core
   localparam int POOL_SIZE   = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_OPS   = 460;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } table_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic                 found;
      logic [VAL_W-1:0]     result_value;
      logic [CNT_OUT_W-1:0] count;
   } table_answer_type;

   logic clock;
   logic reset = 1'b1;

   kvt_req_if req_ch();
   kvt_rsp_if rsp_ch();

   key_value_table_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // table contents as the core should hold them
   logic [KEY_W-1:0]   held_key [ENTRIES];
   logic [VAL_W-1:0]   held_val [ENTRIES];
   logic               held_used[ENTRIES];
   logic [COUNT_W-1:0] held_count;

   table_op_type     pending_ops[$];
   table_answer_type answers_due[$];
   table_op_type     in_flight;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   int n_queued;
   int n_accepted;
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic table_answer_type apply_op(table_op_type op);
      table_answer_type ans;
      int hit;
      int spare;
      hit   = -1;
      spare = -1;
      // scan downward so the lowest matching or free slot wins
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (held_used[i] && held_key[i] == op.key) hit = i;
         if (!held_used[i]) spare = i;
      end
      ans.status       = STAT_MISSING;
      ans.found        = 1'b0;
      ans.result_value = '0;
      case (op.action)
         ACT_PUT: begin
            if (hit >= 0) begin
               held_val[hit] = op.value;
               ans.status    = STAT_UPDATED;
               ans.found     = 1'b1;
            end else if (spare >= 0) begin
               held_key[spare]  = op.key;
               held_val[spare]  = op.value;
               held_used[spare] = 1'b1;
               held_count++;
               ans.status = STAT_INSERTED;
            end else begin
               ans.status = STAT_FULL;
            end
         end
         ACT_GET, ACT_REMOVE: begin
            if (hit >= 0) begin
               ans.status       = STAT_UPDATED;
               ans.found        = 1'b1;
               ans.result_value = held_val[hit];
               if (op.action == ACT_REMOVE) begin
                  held_used[hit] = 1'b0;
                  if (held_count != 0) held_count--;
               end
            end
         end
         default: ;
      endcase
      ans.count = held_count[CNT_OUT_W-1:0];
      return ans;
   endfunction

   task automatic push_op(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      table_op_type op;
      op.action = act;
      op.key    = k;
      op.value  = v;
      pending_ops.push_back(op);
      n_queued++;
   endtask

   task automatic push_random_ops(int n);
      int put_w;
      int roll;
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      put_w = 40;
      for (int j = 0; j < n; j++) begin
         // shift the put/remove balance so the table swings between sparse and full
         if (j % 100 == 0) put_w = $urandom_range(60, 25);
         roll = $urandom_range(99);
         if (roll < put_w) act = ACT_PUT;
         else if (roll < put_w + (100 - put_w) * 6 / 10) act = ACT_GET;
         else if (roll < 97) act = ACT_REMOVE;
         else act = ACT_NONE;
         if ($urandom_range(9) == 0) k = rand64();
         else k = key_pool[$urandom_range(POOL_SIZE - 1)];
         roll = $urandom_range(19);
         if (roll == 0) v = '0;
         else if (roll == 1) v = '1;
         else v = rand64();
         push_op(act, k, v);
      end
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued) @(posedge clock);
   endtask

   // request driver: hold a word until taken, then maybe idle before the next
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            answers_due.push_back(apply_op(in_flight));
            n_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight     = pending_ops.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.action <= in_flight.action;
               req_ch.key    <= in_flight.key;
               req_ch.value  <= in_flight.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response: status %0d found %0d value %h count %0d",
                     $time, rsp_ch.status, rsp_ch.found, rsp_ch.result_value, rsp_ch.count);
            error_count++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.found !== want.found ||
                rsp_ch.result_value !== want.result_value || rsp_ch.count !== want.count) begin
               $display("%0t: mismatch: expected status %0d found %0d value %h count %0d",
                        $time, want.status, want.found, want.result_value, want.count);
               $display("%0t:           got      status %0d found %0d value %h count %0d",
                        $time, rsp_ch.status, rsp_ch.found, rsp_ch.result_value,
                        rsp_ch.count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, answers_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] kmin;
      logic [KEY_W-1:0] kmax;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_PUT;
      req_ch.key    = '0;
      req_ch.value  = '0;
      rsp_ch.ready  = 1'b0;
      n_queued      = 0;
      n_accepted    = 0;
      error_count   = 0;
      cycle_count   = 0;
      held_count    = '0;
      for (int i = 0; i < ENTRIES; i++) held_used[i] = 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 69;
      kmin = {1'b1, {(KEY_W - 1){1'b0}}};
      kmax = {1'b0, {(KEY_W - 1){1'b1}}};

      key_pool[0] = kmin;
      key_pool[1] = kmax;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) begin
         // odd-numbered entries differ from an earlier key in one bit to stress the compare
         if (i % 2 == 0) key_pool[i] = rand64();
         else key_pool[i] = key_pool[$urandom_range(i - 1)] ^ (64'd1 << $urandom_range(63));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, update, remove, ignored code, full table
      push_op(ACT_GET,    '0,   '0);
      push_op(ACT_REMOVE, kmin, '0);
      push_op(ACT_NONE,   '1,   '1);
      push_op(ACT_PUT,    kmin, '1);
      push_op(ACT_PUT,    kmax, '0);
      push_op(ACT_PUT,    '0,   64'h5555_5555_5555_5555);
      push_op(ACT_GET,    kmax, '1);
      push_op(ACT_PUT,    kmin, 64'hAAAA_AAAA_AAAA_AAAA);
      push_op(ACT_GET,    kmin, '0);
      push_op(ACT_REMOVE, kmax, '0);
      push_op(ACT_REMOVE, kmax, '0);
      push_op(ACT_NONE,   kmin, '0);
      for (int j = 0; j < ENTRIES - 2; j++) push_op(ACT_PUT, 64'd1 << (j * 4 + 1), rand64());
      push_op(ACT_PUT,    '1,   '1);
      push_op(ACT_PUT,    '0,   '1);
      push_op(ACT_REMOVE, kmin, '0);

      push_random_ops(PHASE_OPS);
      wait_drained();
      send_idle_pct = 69;
      recv_idle_pct = 34;
      push_random_ops(PHASE_OPS);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random_ops(PHASE_OPS);
      wait_drained();

      while (answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/kvt_pkg.sv
sv/kvt_req_if.sv
sv/kvt_rsp_if.sv
sv/kvt_cell.sv
sv/key_value_table_core.sv
tb/tb_key_value_table_core.sv
